// ===== rtl/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_pkg: ray/cylinder exit point shared definitions
// Field widths, internal pipeline types, status and register codes.
// ----------------------------------------------------------------------------
package rce_pkg;

    localparam int POS_W   = 24;               // Q15.8 positions
    localparam int DIR_W   = 16;               // Q0.15 directions
    localparam int FRAC_W  = DIR_W - 1;
    localparam int LEN_W   = POS_W - 1;
    localparam int SQ_W    = 2 * POS_W;        // squared lengths
    localparam int A_W     = 2 * DIR_W;        // dx^2 + dy^2
    localparam int PM_W    = POS_W + DIR_W;    // |x*dx + y*dy|
    localparam int P_W     = PM_W + 1;         // signed dot product
    localparam int RAD_W   = 2 * PM_W;         // discriminant
    localparam int ROOT_W  = PM_W;             // its square root
    localparam int BN_W    = SQ_W + FRAC_W;    // barrel numerator
    localparam int BD_W    = PM_W + 1;         // barrel denominator
    localparam int CN_W    = POS_W + FRAC_W;   // end-cap numerator
    localparam int CD_W    = DIR_W;            // end-cap denominator
    localparam int DIV_LAT = LEN_W + 1;        // divider register stages
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int PLO_W   = PM_W / 2;
    localparam int PHI_W   = PM_W - PLO_W;
    localparam int HLO_W   = SQ_W / 2;
    localparam int HHI_W   = SQ_W - HLO_W;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [1:0] {
        ST_HIT,
        ST_OUTSIDE,
        ST_NO_CROSS,
        ST_DEGENERATE
    } status_t;

    typedef enum logic {
        REG_BARREL_RADIUS,
        REG_HALF_LENGTH
    } reg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } item_t;

    typedef struct packed {
        status_t                 status;
        logic [LEN_W-1:0]        path_length;
        logic signed [POS_W-1:0] exit_x;
        logic signed [POS_W-1:0] exit_y;
        logic signed [POS_W-1:0] exit_z;
    } result_t;

    // products of the input
    typedef struct packed {
        logic                    valid;
        item_t                   item;
        logic [SQ_W-1:0]         xx;
        logic [SQ_W-1:0]         yy;
        logic [SQ_W-1:0]         rr;
        logic signed [PM_W-1:0]  pxa;
        logic signed [PM_W-1:0]  pyb;
        logic [A_W-1:0]          dxx;
        logic [A_W-1:0]          dyy;
    } s1_t;

    // sums
    typedef struct packed {
        logic                    valid;
        item_t                   item;
        logic [SQ_W-1:0]         r2;
        logic [SQ_W-1:0]         rr;
        logic signed [P_W-1:0]   p;
        logic [A_W-1:0]          a;
    } s2_t;

    // classified, carried until the dividers launch
    typedef struct packed {
        logic                    valid;
        item_t                   item;
        logic                    outside;
        logic [SQ_W-1:0]         h;
        logic [PM_W-1:0]         pmag;
        logic                    p_pos;
        logic [A_W-1:0]          a;
        logic [CN_W-1:0]         cap_num;
        logic [CD_W-1:0]         cap_den;
        logic                    dz_zero;
    } s3_t;

    typedef struct packed {
        s3_t                     base;
        logic [2*PHI_W-1:0]      pp_hh;
        logic [PHI_W+PLO_W-1:0]  pp_hl;
        logic [2*PLO_W-1:0]      pp_ll;
        logic [A_W+HHI_W-1:0]    ah_hi;
        logic [A_W+HLO_W-1:0]    ah_lo;
    } s4_t;

    typedef struct packed {
        s3_t                     base;
        logic [RAD_W-1:0]        psq;
        logic [RAD_W-1:0]        ah;
    } s5_t;

    typedef struct packed {
        status_t                 status;
        s3_t                     base;
    } sq_side_t;

    typedef struct packed {
        logic                    valid;
        status_t                 status;
        item_t                   item;
        logic                    dz_zero;
    } div_side_t;

endpackage

// ===== rtl/rce_div.sv =====
// ----------------------------------------------------------------------------
// rce_div: pipelined saturating divider
// floor(num / den) with one quotient bit per stage, saturates to all ones.
// ----------------------------------------------------------------------------
module rce_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 41,
    parameter int QUO_W = 23
) (
    input  logic             clk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int TOP_W = NUM_W - QUO_W;
    localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    logic [CMP_W-1:0] top_c;
    logic [CMP_W-1:0] den_c;

    logic [DEN_W-1:0] rem_reg [0:QUO_W-1];
    logic [QUO_W-1:0] low_reg [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             sat_reg [0:QUO_W];

    assign top_c = CMP_W'(num[NUM_W-1:QUO_W]);
    assign den_c = CMP_W'(den);

    // quotient would not fit: numerator high part already reaches den
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= top_c[DEN_W-1:0];
            low_reg[0] <= num[QUO_W-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= (top_c >= den_c);
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;
        logic [DEN_W:0] diff;

        assign trial = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});
        assign diff  = ge ? (trial - {1'b0, den_reg[k-1]}) : trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], ge};
                sat_reg[k] <= sat_reg[k-1];
            end
        end

        if (k < QUO_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= diff[DEN_W-1:0];
                    low_reg[k] <= {low_reg[k-1][QUO_W-2:0], 1'b0};
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = sat_reg[QUO_W] ? '1 : quo_reg[QUO_W];

endmodule

// ===== rtl/ray_cylinder_exit_point_top.sv =====
// ----------------------------------------------------------------------------
// ray_cylinder_exit_point_top: exit point of a ray from a closed cylinder
// Throughput: one beat per cycle while the skid register is empty; the 40-stage
// root pipeline and the two 24-stage dividers each retire one item per cycle.
// item_ready drops only while the output skid register is full.
// Reset (rst_n low, async): pipeline, output and skid empty, both registers 0.
// ----------------------------------------------------------------------------
module ray_cylinder_exit_point_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           item_valid,
    output logic                           item_ready,
    input  rce_pkg::item_t                 item,
    // result channel
    output logic                           result_valid,
    input  logic                           result_ready,
    output rce_pkg::result_t               result,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rce_pkg::ADDR_W-1:0]     paddr,
    input  logic [rce_pkg::DATA_W-1:0]     pwdata,
    output logic [rce_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    import rce_pkg::*;

    localparam int RW_W = ROOT_W + 3;   // root remainder

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] barrel_radius_reg;
    logic [LEN_W-1:0] half_length_reg;
    reg_index_t       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            barrel_radius_reg <= '0;
            half_length_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_BARREL_RADIUS: barrel_radius_reg <= pwdata[LEN_W-1:0];
                REG_HALF_LENGTH:   half_length_reg   <= pwdata[LEN_W-1:0];
                default:           barrel_radius_reg <= barrel_radius_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BARREL_RADIUS: prdata = DATA_W'(barrel_radius_reg);
            REG_HALF_LENGTH:   prdata = DATA_W'(half_length_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the skid
    // register is holding a beat.
    // ------------------------------------------------------------------
    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign adv        = !skid_valid_reg;
    assign item_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: squares and dot-product terms
    // ------------------------------------------------------------------
    s1_t s1_reg, s1_next;

    always_comb
    begin
        s1_next.valid = item_valid;
        s1_next.item  = item;
        s1_next.xx    = SQ_W'($signed(item.start_x)) * SQ_W'($signed(item.start_x));
        s1_next.yy    = SQ_W'($signed(item.start_y)) * SQ_W'($signed(item.start_y));
        s1_next.rr    = SQ_W'(barrel_radius_reg) * SQ_W'(barrel_radius_reg);
        s1_next.pxa   = PM_W'($signed(item.start_x)) * PM_W'($signed(item.dir_x));
        s1_next.pyb   = PM_W'($signed(item.start_y)) * PM_W'($signed(item.dir_y));
        s1_next.dxx   = A_W'($signed(item.dir_x)) * A_W'($signed(item.dir_x));
        s1_next.dyy   = A_W'($signed(item.dir_y)) * A_W'($signed(item.dir_y));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else if (adv)
            s1_reg <= s1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: r^2, a = dx^2 + dy^2, p = x*dx + y*dy
    // ------------------------------------------------------------------
    s2_t s2_reg, s2_next;

    always_comb
    begin
        s2_next.valid = s1_reg.valid;
        s2_next.item  = s1_reg.item;
        s2_next.r2    = s1_reg.xx + s1_reg.yy;
        s2_next.rr    = s1_reg.rr;
        s2_next.p     = P_W'(s1_reg.pxa) + P_W'(s1_reg.pyb);
        s2_next.a     = s1_reg.dxx + s1_reg.dyy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_reg <= '0;
        else if (adv)
            s2_reg <= s2_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: inside test, h = R^2 - r^2, |p|, end-cap operands
    // ------------------------------------------------------------------
    s3_t s3_reg, s3_next;
    logic signed [POS_W:0] z_ext;
    logic signed [POS_W:0] hl_ext;
    logic signed [POS_W:0] z_mag;
    logic signed [POS_W:0] gap;
    logic signed [DIR_W:0] dz_ext;
    logic signed [DIR_W:0] dz_mag;

    assign z_ext  = (POS_W+1)'($signed(s2_reg.item.start_z));
    assign hl_ext = $signed({2'b00, half_length_reg});
    assign z_mag  = (z_ext < 0) ? -z_ext : z_ext;
    assign dz_ext = (DIR_W+1)'($signed(s2_reg.item.dir_z));
    assign dz_mag = (dz_ext < 0) ? -dz_ext : dz_ext;
    assign gap    = (dz_ext > 0) ? (hl_ext - z_ext) : (hl_ext + z_ext);

    always_comb
    begin
        s3_next.valid   = s2_reg.valid;
        s3_next.item    = s2_reg.item;
        s3_next.outside = (s2_reg.r2 >= s2_reg.rr) || (z_mag >= hl_ext);
        s3_next.h       = s2_reg.rr - s2_reg.r2;
        s3_next.p_pos   = (s2_reg.p > 0);
        s3_next.pmag    = (s2_reg.p < 0) ? PM_W'(-s2_reg.p) : PM_W'(s2_reg.p);
        s3_next.a       = s2_reg.a;
        s3_next.cap_num = {gap[POS_W-1:0], {FRAC_W{1'b0}}};
        s3_next.cap_den = dz_mag[CD_W-1:0];
        s3_next.dz_zero = (dz_ext == 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_reg <= '0;
        else if (adv)
            s3_reg <= s3_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: partial products of p^2 and a*h (split into halves)
    // ------------------------------------------------------------------
    s4_t s4_reg, s4_next;
    logic [PHI_W-1:0] p_hi;
    logic [PLO_W-1:0] p_lo;
    logic [HHI_W-1:0] h_hi;
    logic [HLO_W-1:0] h_lo;

    assign p_hi = s3_reg.pmag[PM_W-1:PLO_W];
    assign p_lo = s3_reg.pmag[PLO_W-1:0];
    assign h_hi = s3_reg.h[SQ_W-1:HLO_W];
    assign h_lo = s3_reg.h[HLO_W-1:0];

    always_comb
    begin
        s4_next.base  = s3_reg;
        s4_next.pp_hh = (2*PHI_W)'(p_hi) * (2*PHI_W)'(p_hi);
        s4_next.pp_hl = (PHI_W+PLO_W)'(p_hi) * (PHI_W+PLO_W)'(p_lo);
        s4_next.pp_ll = (2*PLO_W)'(p_lo) * (2*PLO_W)'(p_lo);
        s4_next.ah_hi = (A_W+HHI_W)'(s3_reg.a) * (A_W+HHI_W)'(h_hi);
        s4_next.ah_lo = (A_W+HLO_W)'(s3_reg.a) * (A_W+HLO_W)'(h_lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_reg <= '0;
        else if (adv)
            s4_reg <= s4_next;
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine p^2 and a*h
    // ------------------------------------------------------------------
    s5_t s5_reg, s5_next;

    always_comb
    begin
        s5_next.base = s4_reg.base;
        s5_next.psq  = (RAD_W'(s4_reg.pp_hh) << (2*PLO_W))
                     + (RAD_W'(s4_reg.pp_hl) << (PLO_W+1))
                     + RAD_W'(s4_reg.pp_ll);
        s5_next.ah   = (RAD_W'(s4_reg.ah_hi) << HLO_W) + RAD_W'(s4_reg.ah_lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_reg <= '0;
        else if (adv)
            s5_reg <= s5_next;
    end

    // ------------------------------------------------------------------
    // Stage 6: discriminant, status; feeds the root pipeline.
    // Root: restoring, two radicand bits per stage, ROOT_W stages.
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]  rad_next;
    status_t           st_next;
    logic [RAD_W-1:0]  sq_rad_reg  [0:ROOT_W];
    logic [RW_W-1:0]   sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [0:ROOT_W];
    sq_side_t          sq_side_reg [0:ROOT_W];

    assign rad_next = s5_reg.psq + s5_reg.ah;

    always_comb
    begin
        if (s5_reg.base.outside)
            st_next = ST_OUTSIDE;
        else if ((s5_reg.base.a == '0) || (rad_next == '0))
            st_next = ST_DEGENERATE;
        else
            st_next = ST_HIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_side_reg[0] <= '0;
        else if (adv)
            sq_side_reg[0] <= '{status: st_next, base: s5_reg.base};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rad_reg[0]  <= rad_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_root
        logic [RW_W-1:0] rem_sh;
        logic [RW_W-1:0] trial;
        logic            ge;

        assign rem_sh = {sq_rem_reg[k-1][RW_W-3:0], sq_rad_reg[k-1][RAD_W-1 -: 2]};
        assign trial  = {1'b0, sq_root_reg[k-1], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_side_reg[k] <= '0;
            else if (adv)
                sq_side_reg[k] <= sq_side_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rad_reg[k]  <= {sq_rad_reg[k-1][RAD_W-3:0], 2'b00};
                sq_rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[k] <= {sq_root_reg[k-1][ROOT_W-2:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Launch stage: barrel and end-cap divider operands.
    //   p > 0 : h * 2^F / (s + p)
    //   else  : (s - p) * 2^F / a
    // ------------------------------------------------------------------
    sq_side_t         sq_last;
    logic [BD_W-1:0]  root_sum;
    logic [BN_W-1:0]  bar_num_reg;
    logic [BD_W-1:0]  bar_den_reg;
    logic [CN_W-1:0]  cap_num_reg;
    logic [CD_W-1:0]  cap_den_reg;
    div_side_t        dv_side_reg [0:DIV_LAT];

    assign sq_last  = sq_side_reg[ROOT_W];
    assign root_sum = BD_W'(sq_root_reg[ROOT_W]) + BD_W'(sq_last.base.pmag);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bar_num_reg <= sq_last.base.p_pos ? (BN_W'(sq_last.base.h) << FRAC_W)
                                               : (BN_W'(root_sum) << FRAC_W);
            bar_den_reg <= sq_last.base.p_pos ? root_sum : BD_W'(sq_last.base.a);
            cap_num_reg <= sq_last.base.cap_num;
            cap_den_reg <= sq_last.base.cap_den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_side_reg[0] <= '0;
        else if (adv)
            dv_side_reg[0] <= '{valid:   sq_last.base.valid,
                                status:  sq_last.status,
                                item:    sq_last.base.item,
                                dz_zero: sq_last.base.dz_zero};
    end

    for (genvar k = 1; k <= DIV_LAT; k++)
    begin : g_dv_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_side_reg[k] <= '0;
            else if (adv)
                dv_side_reg[k] <= dv_side_reg[k-1];
        end
    end

    logic [LEN_W-1:0] bar_q;
    logic [LEN_W-1:0] cap_q;

    rce_div #(
        .NUM_W (BN_W),
        .DEN_W (BD_W),
        .QUO_W (LEN_W)
    ) u_bar_div (
        .clk (clk),
        .adv (adv),
        .num (bar_num_reg),
        .den (bar_den_reg),
        .quo (bar_q)
    );

    rce_div #(
        .NUM_W (CN_W),
        .DEN_W (CD_W),
        .QUO_W (LEN_W)
    ) u_cap_div (
        .clk (clk),
        .adv (adv),
        .num (cap_num_reg),
        .den (cap_den_reg),
        .quo (cap_q)
    );

    // ------------------------------------------------------------------
    // Path = min(barrel, end cap); a flat direction has no cap limit
    // ------------------------------------------------------------------
    div_side_t        dv_last;
    logic [LEN_W-1:0] cap_lim;
    logic [LEN_W-1:0] path_reg;
    div_side_t        pa_side_reg;

    assign dv_last = dv_side_reg[DIV_LAT];
    assign cap_lim = dv_last.dz_zero ? LEN_MAX : cap_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pa_side_reg <= '0;
        else if (adv)
            pa_side_reg <= dv_last;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            path_reg <= (bar_q < cap_lim) ? bar_q : cap_lim;
    end

    // ------------------------------------------------------------------
    // Step products path * dir
    // ------------------------------------------------------------------
    localparam int PR_W = POS_W + DIR_W;

    logic signed [PR_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic [LEN_W-1:0]       path_d_reg;
    div_side_t              pr_side_reg;
    logic signed [PR_W-1:0] path_s;

    assign path_s = $signed(PR_W'(path_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_side_reg <= '0;
        else if (adv)
            pr_side_reg <= pa_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg <= path_s * PR_W'($signed(pa_side_reg.item.dir_x));
            prod_y_reg <= path_s * PR_W'($signed(pa_side_reg.item.dir_y));
            prod_z_reg <= path_s * PR_W'($signed(pa_side_reg.item.dir_z));
            path_d_reg <= path_reg;
        end
    end

    // ------------------------------------------------------------------
    // Exit coordinates: start + round(prod / 2^F), saturated
    // ------------------------------------------------------------------
    function automatic logic signed [POS_W-1:0] exit_coord(
        input logic signed [POS_W-1:0] start,
        input logic signed [PR_W-1:0]  prod
    );
        logic signed [PR_W-1:0] rnd;
        logic signed [PR_W:0]   sum;
        logic signed [PR_W:0]   pos_max;
        logic signed [PR_W:0]   pos_min;
        rnd     = (prod + PR_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
        sum     = (PR_W+1)'(start) + (PR_W+1)'(rnd);
        pos_max = (PR_W+1)'({1'b0, {(POS_W-1){1'b1}}});
        pos_min = -pos_max - 1;
        if (sum > pos_max)
            exit_coord = {1'b0, {(POS_W-1){1'b1}}};
        else if (sum < pos_min)
            exit_coord = {1'b1, {(POS_W-1){1'b0}}};
        else
            exit_coord = sum[POS_W-1:0];
    endfunction

    result_t pipe_data_reg, pipe_data_next;
    logic    pipe_valid_reg;
    logic    hit;

    assign hit = (pr_side_reg.status == ST_HIT);

    always_comb
    begin
        pipe_data_next.status      = pr_side_reg.status;
        pipe_data_next.path_length = hit ? path_d_reg : '0;
        pipe_data_next.exit_x      = hit ? exit_coord(pr_side_reg.item.start_x, prod_x_reg)
                                         : '0;
        pipe_data_next.exit_y      = hit ? exit_coord(pr_side_reg.item.start_y, prod_y_reg)
                                         : '0;
        pipe_data_next.exit_z      = hit ? exit_coord(pr_side_reg.item.start_z, prod_z_reg)
                                         : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_valid_reg <= 1'b0;
        else if (adv)
            pipe_valid_reg <= pr_side_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pipe_data_reg <= pipe_data_next;
    end

    // ------------------------------------------------------------------
    // Output register plus skid: a stalled result beat never blocks the
    // pipeline until a second finished beat is waiting.
    // ------------------------------------------------------------------
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || pipe_valid_reg;
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_valid_reg && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data_reg;
        if (!out_free && adv)
            skid_data_reg <= pipe_data_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result_ready))
        else $error("skid filled without an output stall");

    a_no_cross_unused: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status != ST_NO_CROSS))
        else $error("no-forward-crossing status produced");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_HIT)) |->
            ((result.path_length == '0) && (result.exit_x == '0) &&
             (result.exit_y == '0) && (result.exit_z == '0)))
        else $error("non-hit result carries nonzero fields");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for ray_cylinder_exit_point_top
// Drives start/direction beats through the valid/ready input channel and
// checks every result beat against a hand-typed expectation or an in-bench
// integer model of the cylinder exit computation. Registers are written over
// the APB port between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rce_pkg::*;

    localparam int PIPE_LAT = 75;
    localparam longint LMAX = (64'd1 << LEN_W) - 1;
    localparam longint PMAX = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint PMIN = -PMAX - 1;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    ray_cylinder_exit_point_top dut (.*);

    // model copy of the two registers
    logic [LEN_W-1:0] radius_q;
    logic [LEN_W-1:0] half_len_q;

    result_t pending_exits[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // directed rows; has_exp marks rows with a hand-typed expectation
    typedef struct {
        item_t   beat;
        bit      has_exp;
        result_t exp;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // integer model
    // ------------------------------------------------------------------------
    function automatic logic [127:0] isqrt128(logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= v)
                r = t;
        end
        return 128'(r);
    endfunction

    // floor(n/d) saturated at the path maximum
    function automatic longint div_len(logic [127:0] n, logic [127:0] d);
        logic [127:0] q;
        q = n / d;
        return (q > 128'(LMAX)) ? LMAX : longint'(q);
    endfunction

    // start + round(path*dir / 2^F), ties toward +inf, saturated
    function automatic logic [POS_W-1:0] step_coord(longint start, longint path,
                                                    longint dir);
        longint prod;
        longint v;
        prod = path * dir;
        v = start + ((prod + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W);
        if (v > PMAX) v = PMAX;
        if (v < PMIN) v = PMIN;
        return v[POS_W-1:0];
    endfunction

    function automatic result_t predict_exit(item_t it);
        result_t r;
        longint x, y, z, dx, dy, dz, p, rad, hl, cap, bar, path;
        logic [127:0] r2, rr, h, a, disc, s, pm;
        x = it.start_x; y = it.start_y; z = it.start_z;
        dx = it.dir_x; dy = it.dir_y; dz = it.dir_z;
        rad = radius_q; hl = half_len_q;
        r = '0;
        r.status = ST_HIT;
        r2 = 128'(x * x) + 128'(y * y);
        rr = 128'(rad * rad);
        if (r2 >= rr || (z < 0 ? -z : z) >= hl)
        begin
            r.status = ST_OUTSIDE;
            return r;
        end
        if (dz > 0)
            cap = div_len(128'(hl - z) << FRAC_W, 128'(dz));
        else if (dz < 0)
            cap = div_len(128'(hl + z) << FRAC_W, 128'(-dz));
        else
            cap = LMAX;
        a = 128'(dx * dx + dy * dy);
        p = x * dx + y * dy;
        pm = 128'(p < 0 ? -p : p);
        h = rr - r2;
        disc = pm * pm + a * h;
        if (a == 0 || disc == 0)
        begin
            r.status = ST_DEGENERATE;
            return r;
        end
        s = isqrt128(disc);
        if (p > 0)
            bar = div_len(h << FRAC_W, s + pm);
        else
            bar = div_len((s + pm) << FRAC_W, a);
        path = (bar < cap) ? bar : cap;
        r.path_length = path[LEN_W-1:0];
        r.exit_x = step_coord(x, path, dx);
        r.exit_y = step_coord(y, path, dy);
        r.exit_z = step_coord(z, path, dz);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall and checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_exits.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_exits.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, result.status);
                    errors++;
                end
                if (result.path_length !== e.path_length)
                begin
                    $error("path_length exp %0d got %0d", e.path_length,
                           result.path_length);
                    errors++;
                end
                if (result.exit_x !== e.exit_x)
                begin
                    $error("exit_x exp %0d got %0d", e.exit_x, result.exit_x);
                    errors++;
                end
                if (result.exit_y !== e.exit_y)
                begin
                    $error("exit_y exp %0d got %0d", e.exit_y, result.exit_y);
                    errors++;
                end
                if (result.exit_z !== e.exit_z)
                begin
                    $error("exit_z exp %0d got %0d", e.exit_z, result.exit_z);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // setup then access cycle; psel stays up so writes can run back to back
    task automatic write_reg(reg_index_t idx, logic [LEN_W-1:0] val);
        // setup cycle
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= DATA_W'(val);
        @(posedge clk);
        // access cycle; the write lands on the next edge
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_BARREL_RADIUS)
            radius_q = val;
        else
            half_len_q = val;
    endtask

    task automatic set_geometry(logic [LEN_W-1:0] rad, logic [LEN_W-1:0] hl);
        write_reg(REG_BARREL_RADIUS, rad);
        write_reg(REG_HALF_LENGTH, hl);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop sending and wait for the pipeline to drain; every beat yields a result
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_exits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // send one beat; the expectation is queued at the accepting edge
    task automatic send_beat(item_t it, bit has_exp, result_t exp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_exits.push_back(has_exp ? exp : predict_exit(it));
    endtask

    // random point mostly inside the current cylinder
    function automatic item_t random_beat();
        item_t it;
        int rad, hl, sel;
        rad = (radius_q > 2) ? int'(radius_q) : 2;
        hl = (half_len_q > 2) ? int'(half_len_q) : 2;
        sel = $urandom_range(9);
        it.dir_x = DIR_W'($urandom);
        it.dir_y = DIR_W'($urandom);
        it.dir_z = DIR_W'($urandom);
        if (sel == 0)
        begin
            // noise over the whole field range
            it.start_x = POS_W'($urandom);
            it.start_y = POS_W'($urandom);
            it.start_z = POS_W'($urandom);
        end
        else
        begin
            it.start_x = POS_W'($urandom_range(rad * 7 / 10) - rad * 7 / 20);
            it.start_y = POS_W'($urandom_range(rad * 7 / 10) - rad * 7 / 20);
            it.start_z = POS_W'($urandom_range(2 * hl - 2) - (hl - 1));
            if (sel == 1) it.dir_z = '0;
            if (sel == 2) it.dir_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            if (sel == 3) it.dir_y = DIR_W'($urandom_range(3) - 2);
        end
        return it;
    endfunction

    task automatic random_phase(int n);
        result_t none;
        none = '0;
        for (int i = 0; i < n; i++)
            send_beat(random_beat(), 1'b0, none);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        row_t rows[$];
        row_t rw;
        result_t outside_res;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        radius_q = '0;
        half_len_q = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        outside_res = '0;
        outside_res.status = ST_OUTSIDE;

        // after reset the cylinder is empty: every start is outside
        rw.beat = '0; rw.has_exp = 1'b1; rw.exp = outside_res;
        rows.push_back(rw);
        rw.beat = {24'sh7fffff, 24'sh800000, 24'sh7fffff,
                   16'sh8000, 16'sh7fff, 16'sh8000};
        rows.push_back(rw);
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp);
        drain();

        // radius 100.0, half-length 50.0
        set_geometry(23'd25600, 23'd12800);
        rows.delete();
        rw.has_exp = 1'b0; rw.exp = '0;
        // origin, along +x, -x and +z, -z, diagonal
        rw.beat = {24'sd0, 24'sd0, 24'sd0, 16'sh7fff, 16'sd0, 16'sd0}; rows.push_back(rw);
        rw.beat = {24'sd0, 24'sd0, 24'sd0, 16'sh8000, 16'sd0, 16'sh7fff}; rows.push_back(rw);
        rw.beat = {24'sd0, 24'sd0, 24'sd0, 16'sd1, 16'sd0, 16'sh8000}; rows.push_back(rw);
        rw.beat = {24'sd100, -24'sd300, 24'sd5, 16'sd16384, 16'sd16384, 16'sd1000};
        rows.push_back(rw);
        // zero radial direction: degenerate
        rw.beat = {24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sh7fff};
        rw.has_exp = 1'b1; rw.exp = '0; rw.exp.status = ST_DEGENERATE;
        rows.push_back(rw);
        // on the barrel, on the cap or far off on -x: outside
        rw.exp = outside_res;
        rw.beat = {24'sd25600, 24'sd0, 24'sd0, 16'sd1, 16'sd0, 16'sd0}; rows.push_back(rw);
        rw.beat = {24'sd0, 24'sd0, -24'sd12800, 16'sd1, 16'sd0, 16'sd0}; rows.push_back(rw);
        rw.beat = {24'sh800000, 24'sd0, 24'sd0, 16'sd1, 16'sd0, 16'sd0}; rows.push_back(rw);
        rw.has_exp = 1'b0;
        // just inside, pointing outward and inward
        rw.beat = {24'sd25599, 24'sd0, 24'sd12799, 16'sd1, 16'sd0, 16'sd1}; rows.push_back(rw);
        rw.beat = {-24'sd25599, 24'sd0, -24'sd12799, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        rows.push_back(rw);
        rw.beat = {24'sd0, 24'sd25599, 24'sd0, 16'sd0, 16'sh8000, 16'sd0}; rows.push_back(rw);
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp);
        drain();

        // largest cylinder: saturated path and exit coordinates
        set_geometry(23'h7fffff, 23'h7fffff);
        rows.delete();
        rw.has_exp = 1'b0;
        rw.beat = {24'sd0, 24'sd0, 24'sd0, 16'sd1, 16'sd0, 16'sd0}; rows.push_back(rw);
        rw.beat = {24'sh7ff000, 24'sd0, 24'sd0, 16'sd1, 16'sd1, 16'sd0}; rows.push_back(rw);
        rw.beat = {-24'sd5000, 24'sd0, 24'sh800001, 16'sh7fff, 16'sd0, 16'sh8000};
        rows.push_back(rw);
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp);
        drain();

        // random phases: sender/receiver idling varies per phase
        send_idle_pct = 35; recv_idle_pct = 66;
        set_geometry(23'd25600, 23'd12800);
        random_phase(120);
        // sender holds off until every result is back
        drain();
        random_phase(50);
        drain();

        send_idle_pct = 66; recv_idle_pct = 35;
        set_geometry(23'd3, 23'd1);
        random_phase(60);
        drain();
        set_geometry(23'h7fffff, 23'd300);
        random_phase(110);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        set_geometry(23'($urandom_range(23'h7fffff)), 23'($urandom_range(23'h7fffff)));
        random_phase(100);
        drain();
        set_geometry(23'd1000, 23'h7fffff);
        random_phase(60);

        drain();
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
